// ===== rtl/qsl_pkg.sv =====
package qsl_pkg;

    // Buffer and data sizing.
    localparam int MAX_ELEMS   = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(MAX_ELEMS);
    localparam int CNT_W       = ADDR_W + 1;

    // Range stack sizing: one entry holds a low and a high index.
    localparam int STACK_DEPTH = 64;
    localparam int SADDR_W     = $clog2(STACK_DEPTH);
    localparam int SP_W        = SADDR_W + 1;
    localparam int ENTRY_W     = 2 * ADDR_W;

    // Port widths of the item fields.
    localparam int FIELD_W     = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_PIVOT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_WR,
        ST_FIN_WR1,
        ST_FIN_WR2,
        ST_PUSH_HI,
        ST_EMIT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/qsl_cmp.sv =====
module qsl_cmp (
    input  logic signed [qsl_pkg::DATA_WIDTH-1:0] elem,
    input  logic signed [qsl_pkg::DATA_WIDTH-1:0] pivot,
    output logic                                  lt
);
    import qsl_pkg::*;

    // Two's complement compare shared by every step of the partition scan.
    assign lt = (elem < pivot);

endmodule

// ===== rtl/quicksort_lomuto_unit.sv =====
// Channel  | Signals                                      | Handshake
// ---------+----------------------------------------------+----------------------------------
// input    | value[31:0] (signed), last                   | taken when start high, busy low
// result   | sorted_value[31:0] (signed), end_of_set,     | strobe high for one cycle, no stall
//          | overflow                                     |
//
// Loading takes an item whenever start is high and busy is low, and the next item may follow at once.
// After the last item the block is busy for the sort and the emit: each
// partition scans its elements and swaps them through the single write
// port of the buffer.
// Emitting gives one result per cycle.
// Reset clears the counters and the state; buffer contents are left as they are.
// The receiver cannot hold results off, so nothing waits on the output side.
module quicksort_lomuto_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [qsl_pkg::FIELD_W-1:0]   value,
    input  logic                                 last,
    output logic                                 strobe,
    output logic signed [qsl_pkg::FIELD_W-1:0]   sorted_value,
    output logic                                 end_of_set,
    output logic                                 overflow
);
    import qsl_pkg::*;

    // Element buffer and range stack.
    logic signed [DATA_WIDTH-1:0] store_mem [MAX_ELEMS];
    logic [ENTRY_W-1:0]           stack_mem [STACK_DEPTH];

    // Control registers.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic [ADDR_W-1:0] bound_reg, bound_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  emit_idx_reg, emit_idx_next;
    logic              strobe_reg, strobe_next;
    logic              eos_reg, eos_next;

    // Data registers.
    logic signed [DATA_WIDTH-1:0] pivot_reg;
    logic signed [DATA_WIDTH-1:0] rd_a_reg;
    logic signed [DATA_WIDTH-1:0] rd_b_reg;
    logic [ENTRY_W-1:0]           stk_rd_reg;

    // Memory port controls.
    logic                         st_we;
    logic [ADDR_W-1:0]            st_waddr;
    logic signed [DATA_WIDTH-1:0] st_wdata;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_a_addr;
    logic [ADDR_W-1:0]            rd_b_addr;
    logic                         stk_we;
    logic [SADDR_W-1:0]           stk_waddr;
    logic [ENTRY_W-1:0]           stk_wdata;
    logic                         stk_re;
    logic [SADDR_W-1:0]           stk_raddr;
    logic                         pivot_load;

    logic                         elem_lt;
    logic [ADDR_W-1:0]            pop_lo;
    logic [ADDR_W-1:0]            pop_hi;
    logic [CNT_W-1:0]             bound_ext;
    logic [CNT_W-1:0]             lo_ext;
    logic [CNT_W-1:0]             hi_ext;

    assign pop_lo    = stk_rd_reg[ADDR_W-1:0];
    assign pop_hi    = stk_rd_reg[ENTRY_W-1:ADDR_W];
    assign bound_ext = {1'b0, bound_reg};
    assign lo_ext    = {1'b0, lo_reg};
    assign hi_ext    = {1'b0, hi_reg};

    // Shared comparator: scanned element against the pivot.
    qsl_cmp u_cmp (
        .elem  (rd_a_reg),
        .pivot (pivot_reg),
        .lt    (elem_lt)
    );

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            sp_reg       <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            bound_reg    <= '0;
            i_reg        <= '0;
            emit_idx_reg <= '0;
            strobe_reg   <= 1'b0;
            eos_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            sp_reg       <= sp_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            bound_reg    <= bound_next;
            i_reg        <= i_next;
            emit_idx_reg <= emit_idx_next;
            strobe_reg   <= strobe_next;
            eos_reg      <= eos_next;
        end
    end

    // Element buffer: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= store_mem[rd_a_addr];
            rd_b_reg <= store_mem[rd_b_addr];
        end
    end

    // Range stack: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stack_mem[stk_raddr];
        end
    end

    // Pivot holding register.
    always_ff @(posedge clk)
    begin
        if (pivot_load)
        begin
            pivot_reg <= rd_a_reg;
        end
    end

    // Sequencer: load, partition loop, stack handling and emit.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        sp_next       = sp_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        bound_next    = bound_reg;
        i_next        = i_reg;
        emit_idx_next = emit_idx_reg;
        strobe_next   = 1'b0;
        eos_next      = 1'b0;
        st_we         = 1'b0;
        st_waddr      = '0;
        st_wdata      = rd_a_reg;
        rd_en         = 1'b0;
        rd_a_addr     = '0;
        rd_b_addr     = '0;
        stk_we        = 1'b0;
        stk_waddr     = sp_reg[SADDR_W-1:0];
        stk_wdata     = '0;
        stk_re        = 1'b0;
        stk_raddr     = '0;
        pivot_load    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Store the item if there is room, otherwise note the drop.
                    if (count_reg < CNT_W'(MAX_ELEMS))
                    begin
                        st_we      = 1'b1;
                        st_waddr   = count_reg[ADDR_W-1:0];
                        st_wdata   = DATA_WIDTH'(value);
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end

            ST_INIT:
            begin
                // Push the whole buffer as the first range when it holds at least two elements.
                emit_idx_next = '0;
                sp_next       = '0;
                if (count_reg < CNT_W'(2))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = {ADDR_W'(count_reg - CNT_W'(1)), ADDR_W'(0)};
                    sp_next    = SP_W'(1);
                    state_next = ST_POP;
                end
            end

            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    stk_re     = 1'b1;
                    stk_raddr  = SADDR_W'(sp_reg - SP_W'(1));
                    sp_next    = sp_reg - SP_W'(1);
                    state_next = ST_POP_WAIT;
                end
            end

            ST_POP_WAIT:
            begin
                // Skip a range of fewer than two elements or one that lies beyond the data.
                if ((CNT_W'(pop_hi) >= count_reg) || (pop_lo >= pop_hi))
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    lo_next    = pop_lo;
                    hi_next    = pop_hi;
                    bound_next = pop_lo;
                    i_next     = CNT_W'(pop_lo) + CNT_W'(1);
                    rd_en      = 1'b1;
                    rd_a_addr  = pop_lo;
                    state_next = ST_PIVOT;
                end
            end

            ST_PIVOT:
            begin
                pivot_load = 1'b1;
                state_next = ST_SCAN_RD;
            end

            ST_SCAN_RD:
            begin
                rd_en = 1'b1;
                if (i_reg > hi_ext)
                begin
                    // Scan finished: fetch the pivot and its final slot.
                    rd_a_addr  = lo_reg;
                    rd_b_addr  = bound_reg;
                    state_next = ST_FIN_WR1;
                end
                else
                begin
                    rd_a_addr  = i_reg[ADDR_W-1:0];
                    rd_b_addr  = bound_reg + ADDR_W'(1);
                    state_next = ST_SCAN_CMP;
                end
            end

            ST_SCAN_CMP:
            begin
                if (elem_lt)
                begin
                    // Smaller element moves forward to the next bound slot.
                    st_we      = 1'b1;
                    st_waddr   = bound_reg + ADDR_W'(1);
                    st_wdata   = rd_a_reg;
                    bound_next = bound_reg + ADDR_W'(1);
                    state_next = ST_SWAP_WR;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SWAP_WR:
            begin
                st_we      = 1'b1;
                st_waddr   = i_reg[ADDR_W-1:0];
                st_wdata   = rd_b_reg;
                i_next     = i_reg + CNT_W'(1);
                state_next = ST_SCAN_RD;
            end

            ST_FIN_WR1:
            begin
                st_we      = 1'b1;
                st_waddr   = bound_reg;
                st_wdata   = rd_a_reg;
                state_next = ST_FIN_WR2;
            end

            ST_FIN_WR2:
            begin
                st_we    = 1'b1;
                st_waddr = lo_reg;
                st_wdata = rd_b_reg;
                // Lower part holds at least two elements: push it if the stack has room.
                if ((bound_ext >= lo_ext + CNT_W'(2)) && (sp_reg < SP_W'(STACK_DEPTH)))
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {bound_reg - ADDR_W'(1), lo_reg};
                    sp_next   = sp_reg + SP_W'(1);
                end
                state_next = ST_PUSH_HI;
            end

            ST_PUSH_HI:
            begin
                // Upper part holds at least two elements: push it if the stack has room.
                if ((bound_ext + CNT_W'(1) < hi_ext) && (sp_reg < SP_W'(STACK_DEPTH)))
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {hi_reg, bound_reg + ADDR_W'(1)};
                    sp_next   = sp_reg + SP_W'(1);
                end
                state_next = ST_POP;
            end

            ST_EMIT:
            begin
                // Read one element per cycle; the result is registered along with its strobe.
                rd_en         = 1'b1;
                rd_a_addr     = emit_idx_reg[ADDR_W-1:0];
                strobe_next   = 1'b1;
                eos_next      = ((emit_idx_reg + CNT_W'(1)) == count_reg);
                emit_idx_next = emit_idx_reg + CNT_W'(1);
                if ((emit_idx_reg + CNT_W'(1)) == count_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Final result is on the ports now; clear for the next set.
                count_next   = '0;
                dropped_next = 1'b0;
                sp_next      = '0;
                state_next   = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    assign busy         = (state_reg != ST_IDLE);
    assign strobe       = strobe_reg;
    assign sorted_value = FIELD_W'(rd_a_reg);
    assign end_of_set   = eos_reg;
    assign overflow     = dropped_reg;

    // Results only appear while a set is being worked on.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result strobe while idle");

    // The end marker travels with a result.
    a_eos_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        end_of_set |-> strobe)
        else $error("end_of_set without strobe");

    // The block returns to idle only right after the final result.
    a_idle_after_eos: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(end_of_set))
        else $error("idle reached without final result");

    // Buffer fill and stack depth stay within their capacities.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(MAX_ELEMS)) && (sp_reg <= SP_W'(STACK_DEPTH)))
        else $error("buffer or stack overrun");

    // Loading never happens during a sort.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (count_reg == $past(count_reg)) || (count_reg == '0))
        else $error("element count changed while busy");

endmodule

// ===== sim/quicksort_lomuto_unit_tb.sv =====
`timescale 1ns / 100ps

module quicksort_lomuto_unit_tb;

    import qsl_pkg::*;

    localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam int unsigned STALL_LIMIT = 40000;
    localparam int unsigned RANDOM_ITEMS = 24;

    typedef logic signed [FIELD_W-1:0] value_list_t[$];

    typedef struct {
        logic signed [FIELD_W-1:0] sorted_value;
        logic                      end_of_set;
        logic                      overflow;
    } sorted_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [FIELD_W-1:0] value;
    logic                      last;
    logic                      strobe;
    logic signed [FIELD_W-1:0] sorted_value;
    logic                      end_of_set;
    logic                      overflow;

    // Own copy of the block's set buffer and its flags.
    logic signed [FIELD_W-1:0] set_store [MAX_ELEMS];
    int unsigned               set_count;
    bit                        set_dropped;

    // Sorted values still to come out of the block, oldest first.
    sorted_result_t            pending_sorted[$];

    int unsigned               mismatch_count;
    int unsigned               stall_cycles;

    quicksort_lomuto_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .end_of_set   (end_of_set),
        .overflow     (overflow)
    );

    // Free-running clock, 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Quicksort of the stored set: first element as pivot, Lomuto scan,
    // pending ranges kept on an explicit stack.
    function automatic void sort_stored_set();
        int lo_stack [STACK_DEPTH];
        int hi_stack [STACK_DEPTH];
        int sp;
        int lo;
        int hi;
        int bound;
        logic signed [FIELD_W-1:0] pivot;
        logic signed [FIELD_W-1:0] tmp;
        sp = 0;
        if (set_count < 2)
            return;
        lo_stack[0] = 0;
        hi_stack[0] = set_count - 1;
        sp = 1;
        while (sp > 0)
        begin
            sp--;
            lo = lo_stack[sp];
            hi = hi_stack[sp];
            if (hi >= int'(set_count) || lo >= hi)
                continue;
            pivot = set_store[lo];
            bound = lo;
            for (int i = lo + 1; i <= hi; i++)
            begin
                if (set_store[i] < pivot)
                begin
                    bound++;
                    tmp = set_store[i];
                    set_store[i] = set_store[bound];
                    set_store[bound] = tmp;
                end
            end
            tmp = set_store[lo];
            set_store[lo] = set_store[bound];
            set_store[bound] = tmp;
            // Ranges of fewer than two elements are not pushed.
            if (bound > lo + 1 && sp < STACK_DEPTH)
            begin
                lo_stack[sp] = lo;
                hi_stack[sp] = bound - 1;
                sp++;
            end
            if (bound + 1 < hi && sp < STACK_DEPTH)
            begin
                lo_stack[sp] = bound + 1;
                hi_stack[sp] = hi;
                sp++;
            end
        end
    endfunction

    // Update the model with one accepted item and queue the sorted set
    // when the item closes it.
    function automatic void predict_sorted_set(logic signed [FIELD_W-1:0] v, bit is_last);
        sorted_result_t r;
        if (set_count < MAX_ELEMS)
        begin
            set_store[set_count] = v;
            set_count++;
        end
        else
            set_dropped = 1'b1;
        if (!is_last)
            return;
        sort_stored_set();
        for (int i = 0; i < int'(set_count); i++)
        begin
            r.sorted_value = set_store[i];
            r.end_of_set   = (i + 1 == int'(set_count));
            r.overflow     = set_dropped;
            pending_sorted.push_back(r);
        end
        set_count   = 0;
        set_dropped = 1'b0;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly ordinary 32-bit values, with extremes and a narrow band that
    // produces plenty of duplicates.
    function automatic logic signed [FIELD_W-1:0] rand_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            1, 2: return $signed($urandom_range(0, 8)) - 32'sd4;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned rand_set_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 8);
        else if (r < 95)
            return $urandom_range(9, 20);
        return $urandom_range(30, MAX_ELEMS);
    endfunction

    task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want_v, got_v, $realtime);
        mismatch_count++;
    endtask

    // Offer one item after an optional gap and hold it until it is taken.
    task automatic send_item(input logic signed [FIELD_W-1:0] v, input bit is_last,
                             input int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        last  <= is_last;
        do
            @(posedge clk);
        while (busy);
        predict_sorted_set(v, is_last);
    endtask

    task automatic send_set(input value_list_t vals, input bit no_gaps);
        for (int i = 0; i < vals.size(); i++)
            send_item(vals[i], i == vals.size() - 1, no_gaps ? 0 : gap_len());
    endtask

    // Sender holds off until every queued result has come out.
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_sorted.size() != 0)
            @(posedge clk);
    endtask

    // Single elements, the value extremes, ordered and reversed sets, duplicates.
    task automatic test_directed();
        send_set('{VAL_MIN}, 1'b1);
        send_set('{VAL_MAX}, 1'b0);
        send_set('{VAL_MAX, VAL_MIN}, 1'b1);
        send_set('{-32'sd1, -32'sd1}, 1'b0);
        send_set('{VAL_MIN, -32'sd1, 32'sd0, 32'sd1, VAL_MAX}, 1'b1);
        send_set('{VAL_MAX, 32'sd1, 32'sd0, -32'sd1, VAL_MIN}, 1'b0);
        send_set('{32'sd3, -32'sd3, 32'sd3, 32'sd0, -32'sd3, 32'sd3}, 1'b1);
        wait_for_drain();
    endtask

    // A descending set one item longer than the buffer: the buffer fills,
    // the final item is dropped and every result carries the overflow flag.
    task automatic test_overflow();
        value_list_t vals;
        for (int i = 0; i < MAX_ELEMS + 1; i++)
            vals.push_back(32'sd1000 - 32'sd37 * i);
        send_set(vals, 1'b0);
        wait_for_drain();
    endtask

    // Random sets, mostly small, some sent without any gaps.
    task automatic test_random_sets();
        value_list_t vals;
        int unsigned sent;
        int unsigned n;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            vals.delete();
            n = rand_set_size();
            for (int i = 0; i < int'(n); i++)
                vals.push_back(rand_value());
            send_set(vals, $urandom_range(0, 2) == 0);
            sent += n;
            if ($urandom_range(0, 3) == 0)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    // Each result is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        sorted_result_t want;
        if (rst_n && strobe)
        begin
            if (pending_sorted.size() == 0)
                report_mismatch("unexpected result, sorted_value", 0, sorted_value);
            else
            begin
                want = pending_sorted.pop_front();
                if (sorted_value !== want.sorted_value)
                    report_mismatch("sorted_value", want.sorted_value, sorted_value);
                if (end_of_set !== want.end_of_set)
                    report_mismatch("end_of_set", want.end_of_set, end_of_set);
                if (overflow !== want.overflow)
                    report_mismatch("overflow", want.overflow, overflow);
            end
        end
    end

    // Watchdog on cycles in which no item is taken and no result appears.
    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        value          <= '0;
        last           <= 1'b0;
        set_count      = 0;
        set_dropped    = 1'b0;
        mismatch_count = 0;
        stall_cycles   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow();
        test_random_sets();

        repeat (20) @(posedge clk);
        if (pending_sorted.size() != 0)
            report_mismatch("results never produced", pending_sorted.size(), 0);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
